>>> design/fmprf_pkg.sv
// shared types and constants for the first-match packet rule filter
// no dependencies

package fmprf_pkg;

  localparam logic [1:0] FUNC_CLASSIFY = 2'd0;
  localparam logic [1:0] FUNC_APPEND   = 2'd1;
  localparam logic [1:0] FUNC_DELETE   = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_BAD_NUM  = 2'd2;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [1:0] RPROTO_ANY = 2'd0;
  localparam logic [1:0] RPROTO_TCP = 2'd1;
  localparam logic [1:0] RPROTO_UDP = 2'd2;

  localparam int unsigned AddrBits = 32;

  // one stored rule
  typedef struct packed {
    logic [1:0]  dir;
    logic [31:0] src_addr;
    logic [31:0] src_keep;
    logic [31:0] dst_addr;
    logic [31:0] dst_keep;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [1:0]  proto;
    logic        verdict;
  } rule_t;

  // classified word passed from front to back
  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  dir;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  protocol;
    logic        is_tcp;
    logic        is_udp;
    logic [31:0] src_keep;
    logic [31:0] dst_keep;
    logic        rule_action;
    logic [4:0]  rule_number;
  } cmd_t;

  // prefix keep mask from a netmask: leading ones, mask 0 means all 32 bits
  function automatic logic [31:0] keep_of(input logic [31:0] mask);
    logic [31:0] k;
    logic        run;
    k   = '0;
    run = 1'b1;
    if (mask == '0) begin
      k = '1;
    end else begin
      for (int b = 31; b >= 0; b--) begin
        run  = run & mask[b];
        k[b] = run;
      end
    end
    return k;
  endfunction

endpackage

>>> design/first_match_packet_rule_filter_core.sv
// first-match packet rule filter: start is registered in the front part, then in the back part to give done_o
// throughput one word per cycle; busy never rises since the back end
// takes a word every cycle and results cannot be stalled
// reset empties the rule table; rule contents are unknown until appended
// depends on fmprf_pkg, fmprf_front, fmprf_back

module first_match_packet_rule_filter_core #(
  parameter int unsigned MAX_RULES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [1:0]  direction_i,
  input  logic [31:0] src_ip_i,
  input  logic [31:0] dst_ip_i,
  input  logic [15:0] sport_i,
  input  logic [15:0] dport_i,
  input  logic [7:0]  protocol_i,
  input  logic [31:0] src_mask_i,
  input  logic [31:0] dst_mask_i,
  input  logic        rule_action_i,
  input  logic [4:0]  rule_number_i,
  output logic        done_o,
  output logic        verdict_o,
  output logic        hit_o,
  output logic [4:0]  hit_position_o,
  output logic [1:0]  status_o
);
  import fmprf_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  // front: accept and classify
  fmprf_front u_front (
    .clk_i, .rst_ni,
    .start_i(start), .busy_o(busy),
    .func_i, .direction_i, .src_ip_i, .dst_ip_i, .sport_i, .dport_i,
    .protocol_i, .src_mask_i, .dst_mask_i, .rule_action_i, .rule_number_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_ready_i(cmd_ready)
  );

  // back: rule table and lookup
  fmprf_back #(.MaxRules(MAX_RULES)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_ready_o(cmd_ready),
    .done_o, .verdict_o, .hit_o, .hit_position_o, .status_o
  );

endmodule

>>> design/fmprf_front.sv
// front part: takes commands, normalizes ports and builds prefix masks
// depends on fmprf_pkg

module fmprf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         func_i,
  input  logic [1:0]         direction_i,
  input  logic [31:0]        src_ip_i,
  input  logic [31:0]        dst_ip_i,
  input  logic [15:0]        sport_i,
  input  logic [15:0]        dport_i,
  input  logic [7:0]         protocol_i,
  input  logic [31:0]        src_mask_i,
  input  logic [31:0]        dst_mask_i,
  input  logic               rule_action_i,
  input  logic [4:0]         rule_number_i,
  output logic               cmd_valid_o,
  output fmprf_pkg::cmd_t    cmd_o,
  input  logic               cmd_ready_i
);
  import fmprf_pkg::*;

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic is_tcp, is_udp, take;

  assign busy_o = valid_q && !cmd_ready_i;
  assign take   = start_i && !busy_o;
  assign is_tcp = (protocol_i == PROTO_TCP);
  assign is_udp = (protocol_i == PROTO_UDP);

  // build classified word
  always_comb begin
    cmd_d = cmd_q;
    valid_d = valid_q && !cmd_ready_i;
    if (take) begin
      valid_d          = 1'b1;
      cmd_d.func       = func_i;
      cmd_d.dir        = direction_i;
      cmd_d.src_ip     = src_ip_i;
      cmd_d.dst_ip     = dst_ip_i;
      cmd_d.is_tcp     = is_tcp;
      cmd_d.is_udp     = is_udp;
      cmd_d.protocol   = protocol_i;
      // ports zeroed for non tcp/udp packets only on classify
      if (func_i == FUNC_CLASSIFY && !is_tcp && !is_udp) begin
        cmd_d.sport = '0;
        cmd_d.dport = '0;
      end else begin
        cmd_d.sport = sport_i;
        cmd_d.dport = dport_i;
      end
      cmd_d.src_keep    = keep_of(src_mask_i);
      cmd_d.dst_keep    = keep_of(dst_mask_i);
      cmd_d.rule_action = rule_action_i;
      cmd_d.rule_number = rule_number_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

>>> design/fmprf_back.sv
// back part: rule table, parallel first-match lookup, append and delete
// depends on fmprf_pkg

module fmprf_back #(
  parameter int unsigned MaxRules = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  fmprf_pkg::cmd_t cmd_i,
  output logic            cmd_ready_o,
  output logic            done_o,
  output logic            verdict_o,
  output logic            hit_o,
  output logic [4:0]      hit_position_o,
  output logic [1:0]      status_o
);
  import fmprf_pkg::*;

  localparam int unsigned CntW = $clog2(MaxRules + 1);
  localparam int unsigned IdxW = (MaxRules > 1) ? $clog2(MaxRules) : 1;
  localparam int unsigned CmpW = (CntW > 5) ? CntW : 5;

  rule_t             rules_q [MaxRules];
  logic [CntW-1:0]   count_q, count_d;
  logic [MaxRules-1:0] match;
  logic              done_q, verdict_q, hit_q;
  logic [4:0]        pos_q;
  logic [1:0]        status_q;
  logic              go;

  // one command per cycle
  assign cmd_ready_o = 1'b1;
  assign go = cmd_valid_i;

  // per-rule match lanes
  always_comb begin
    for (int r = 0; r < MaxRules; r++) begin
      match[r] = (CntW'(r) < count_q)
        && (rules_q[r].dir == cmd_i.dir)
        && !(rules_q[r].proto == RPROTO_TCP && !cmd_i.is_tcp)
        && !(rules_q[r].proto == RPROTO_UDP && !cmd_i.is_udp)
        && (rules_q[r].src_addr == '0 ||
            ((cmd_i.src_ip ^ rules_q[r].src_addr) & rules_q[r].src_keep) == '0)
        && (rules_q[r].dst_addr == '0 ||
            ((cmd_i.dst_ip ^ rules_q[r].dst_addr) & rules_q[r].dst_keep) == '0)
        && (rules_q[r].sport == '0 || rules_q[r].sport == cmd_i.sport)
        && (rules_q[r].dport == '0 || rules_q[r].dport == cmd_i.dport);
    end
  end

  // first-match priority pick
  logic            any_hit;
  logic [IdxW-1:0] first_idx;
  always_comb begin
    any_hit   = 1'b0;
    first_idx = '0;
    for (int r = MaxRules - 1; r >= 0; r--) begin
      if (match[r]) begin
        any_hit   = 1'b1;
        first_idx = IdxW'(r);
      end
    end
  end

  logic del_ok, app_ok;
  assign app_ok = (count_q < CntW'(MaxRules));
  assign del_ok = (cmd_i.rule_number != '0)
    && (CmpW'(cmd_i.rule_number) <= CmpW'(count_q));

  // rule count
  always_comb begin
    count_d = count_q;
    if (go && cmd_i.func == FUNC_APPEND && app_ok) count_d = count_q + 1'b1;
    if (go && cmd_i.func == FUNC_DELETE && del_ok) count_d = count_q - 1'b1;
  end

  // table storage: append writes at the end, delete shifts up
  rule_t new_rule;
  always_comb begin
    new_rule.dir      = cmd_i.dir;
    new_rule.src_addr = cmd_i.src_ip;
    new_rule.src_keep = cmd_i.src_keep;
    new_rule.dst_addr = cmd_i.dst_ip;
    new_rule.dst_keep = cmd_i.dst_keep;
    new_rule.sport    = cmd_i.sport;
    new_rule.dport    = cmd_i.dport;
    new_rule.proto    = (cmd_i.protocol == 8'(RPROTO_TCP)) ? RPROTO_TCP :
                        (cmd_i.protocol == 8'(RPROTO_UDP)) ? RPROTO_UDP : RPROTO_ANY;
    new_rule.verdict  = cmd_i.rule_action;
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < MaxRules; r++) begin
      if (go && cmd_i.func == FUNC_APPEND && app_ok && count_q == CntW'(r)) begin
        rules_q[r] <= new_rule;
      end else if (go && cmd_i.func == FUNC_DELETE && del_ok && r + 1 < MaxRules
                   && (r + 1) >= int'(cmd_i.rule_number)) begin
        rules_q[r] <= rules_q[(r + 1) % MaxRules];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= go;
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= 1'b0;
    hit_q     <= 1'b0;
    pos_q     <= '0;
    status_q  <= STATUS_OK;
    case (cmd_i.func)
      FUNC_CLASSIFY: begin
        hit_q     <= any_hit;
        verdict_q <= any_hit ? rules_q[first_idx].verdict : 1'b1;
        pos_q     <= any_hit ? 5'(first_idx) + 5'd1 : 5'd0;
      end
      FUNC_APPEND: begin
        if (!app_ok) status_q <= STATUS_FULL;
      end
      FUNC_DELETE: begin
        if (!del_ok) status_q <= STATUS_BAD_NUM;
      end
      default: begin
      end
    endcase
  end

  assign done_o         = done_q;
  assign verdict_o      = verdict_q;
  assign hit_o          = hit_q;
  assign hit_position_o = pos_q;
  assign status_o       = status_q;

endmodule

>>> test/first_match_packet_rule_filter_core_test.sv
// self-checking testbench for first_match_packet_rule_filter_core
// keeps its own copy of the rule table and predicts every result word
// depends on fmprf_pkg and the core
`timescale 1ns / 100ps

module first_match_packet_rule_filter_core_test;
  import fmprf_pkg::*;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned StallLimit = 2000;
  localparam logic [1:0] FUNC_IGNORED = 2'd3;

  // one input word
  typedef struct {
    logic [1:0]  func;
    logic [1:0]  dir;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  protocol;
    logic [31:0] src_mask;
    logic [31:0] dst_mask;
    logic        action;
    logic [4:0]  number;
  } cmd_word_t;

  // one result word
  typedef struct {
    logic       verdict;
    logic       hit;
    logic [4:0] position;
    logic [1:0] status;
  } verdict_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  func_i;
  logic [1:0]  direction_i;
  logic [31:0] src_ip_i;
  logic [31:0] dst_ip_i;
  logic [15:0] sport_i;
  logic [15:0] dport_i;
  logic [7:0]  protocol_i;
  logic [31:0] src_mask_i;
  logic [31:0] dst_mask_i;
  logic        rule_action_i;
  logic [4:0]  rule_number_i;
  logic        done_o;
  logic        verdict_o;
  logic        hit_o;
  logic [4:0]  hit_position_o;
  logic [1:0]  status_o;

  // shadow rule table
  int unsigned shadow_count;
  logic [1:0]  shadow_dir[TableDepth];
  logic [31:0] shadow_src_addr[TableDepth];
  logic [31:0] shadow_src_mask[TableDepth];
  logic [31:0] shadow_dst_addr[TableDepth];
  logic [31:0] shadow_dst_mask[TableDepth];
  logic [15:0] shadow_sport[TableDepth];
  logic [15:0] shadow_dport[TableDepth];
  logic [1:0]  shadow_proto[TableDepth];
  logic        shadow_verdict[TableDepth];

  verdict_word_t pending_verdicts[$];
  int unsigned   mismatches;
  int unsigned   idle_cycles;
  bit            no_gaps;

  first_match_packet_rule_filter_core #(.MAX_RULES(TableDepth)) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .direction_i    (direction_i),
    .src_ip_i       (src_ip_i),
    .dst_ip_i       (dst_ip_i),
    .sport_i        (sport_i),
    .dport_i        (dport_i),
    .protocol_i     (protocol_i),
    .src_mask_i     (src_mask_i),
    .dst_mask_i     (dst_mask_i),
    .rule_action_i  (rule_action_i),
    .rule_number_i  (rule_number_i),
    .done_o         (done_o),
    .verdict_o      (verdict_o),
    .hit_o          (hit_o),
    .hit_position_o (hit_position_o),
    .status_o       (status_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // prefix keep bits from a netmask: leading ones, zero mask means full length
  function automatic logic [31:0] prefix_keep(input logic [31:0] mask);
    int len;
    len = 0;
    if (mask == '0) begin
      len = 32;
    end else begin
      while (len < 32 && mask[31 - len]) len++;
    end
    return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
  endfunction

  function automatic bit addr_match(input logic [31:0] pkt, input logic [31:0] rule_addr,
                                    input logic [31:0] mask);
    return (rule_addr == '0) || (((pkt ^ rule_addr) & prefix_keep(mask)) == '0);
  endfunction

  // apply one word to the shadow table and return the result it should give
  function automatic verdict_word_t filter_predict(input cmd_word_t w);
    verdict_word_t r;
    logic [15:0]   sp;
    logic [15:0]   dp;
    bit            is_tcp;
    bit            is_udp;
    r = '{verdict: 1'b0, hit: 1'b0, position: 5'd0, status: STATUS_OK};
    is_tcp = (w.protocol == PROTO_TCP);
    is_udp = (w.protocol == PROTO_UDP);
    case (w.func)
      FUNC_CLASSIFY: begin
        r.verdict = 1'b1;
        sp = (is_tcp || is_udp) ? w.sport : 16'd0;
        dp = (is_tcp || is_udp) ? w.dport : 16'd0;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_dir[i] != w.dir) continue;
          if (shadow_proto[i] == RPROTO_TCP && !is_tcp) continue;
          if (shadow_proto[i] == RPROTO_UDP && !is_udp) continue;
          if (!addr_match(w.src_ip, shadow_src_addr[i], shadow_src_mask[i])) continue;
          if (!addr_match(w.dst_ip, shadow_dst_addr[i], shadow_dst_mask[i])) continue;
          if (shadow_sport[i] != '0 && shadow_sport[i] != sp) continue;
          if (shadow_dport[i] != '0 && shadow_dport[i] != dp) continue;
          r.verdict  = shadow_verdict[i];
          r.hit      = 1'b1;
          r.position = 5'(i + 1);
          break;
        end
      end
      FUNC_APPEND: begin
        if (shadow_count >= TableDepth) begin
          r.status = STATUS_FULL;
        end else begin
          shadow_dir[shadow_count]      = w.dir;
          shadow_src_addr[shadow_count] = w.src_ip;
          shadow_src_mask[shadow_count] = w.src_mask;
          shadow_dst_addr[shadow_count] = w.dst_ip;
          shadow_dst_mask[shadow_count] = w.dst_mask;
          shadow_sport[shadow_count]    = w.sport;
          shadow_dport[shadow_count]    = w.dport;
          // unknown protocol codes are stored as any
          shadow_proto[shadow_count] = (w.protocol == 8'(RPROTO_TCP)) ? RPROTO_TCP :
                                       (w.protocol == 8'(RPROTO_UDP)) ? RPROTO_UDP :
                                       RPROTO_ANY;
          shadow_verdict[shadow_count] = w.action;
          shadow_count++;
        end
      end
      FUNC_DELETE: begin
        if (w.number == '0 || w.number > shadow_count) begin
          r.status = STATUS_BAD_NUM;
        end else begin
          for (int i = w.number - 1; i + 1 < shadow_count; i++) begin
            shadow_dir[i]      = shadow_dir[i + 1];
            shadow_src_addr[i] = shadow_src_addr[i + 1];
            shadow_src_mask[i] = shadow_src_mask[i + 1];
            shadow_dst_addr[i] = shadow_dst_addr[i + 1];
            shadow_dst_mask[i] = shadow_dst_mask[i + 1];
            shadow_sport[i]    = shadow_sport[i + 1];
            shadow_dport[i]    = shadow_dport[i + 1];
            shadow_proto[i]    = shadow_proto[i + 1];
            shadow_verdict[i]  = shadow_verdict[i + 1];
          end
          shadow_count--;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // drive one word at the falling edge and hold it until accepted
  task automatic send_word(input cmd_word_t w);
    bit taken;
    @(negedge clk_i);
    start         <= 1'b1;
    func_i        <= w.func;
    direction_i   <= w.dir;
    src_ip_i      <= w.src_ip;
    dst_ip_i      <= w.dst_ip;
    sport_i       <= w.sport;
    dport_i       <= w.dport;
    protocol_i    <= w.protocol;
    src_mask_i    <= w.src_mask;
    dst_mask_i    <= w.dst_mask;
    rule_action_i <= w.action;
    rule_number_i <= w.number;
    forever begin
      #1 taken = !busy;
      @(posedge clk_i);
      if (taken) break;
      @(negedge clk_i);
    end
    pending_verdicts.push_back(filter_predict(w));
    // random gap after the word, none while in burst mode
    if (!no_gaps) begin
      int unsigned pick;
      int unsigned gap;
      pick = $urandom_range(99);
      gap  = (pick < 65) ? 0 : (pick < 95) ? $urandom_range(3, 1) : $urandom_range(30, 8);
      if (gap != 0) begin
        @(negedge clk_i);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  function automatic cmd_word_t blank_word(input logic [1:0] func);
    cmd_word_t w;
    w = '{func: func, dir: 2'd0, src_ip: 32'd0, dst_ip: 32'd0, sport: 16'd0,
          dport: 16'd0, protocol: 8'd0, src_mask: 32'd0, dst_mask: 32'd0,
          action: 1'b0, number: 5'd0};
    return w;
  endfunction

  function automatic logic [31:0] random_mask();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 2) return 32'd0;
    if (pick < 8) return prefix_keep(32'hFFFF_FFFF << (32 - $urandom_range(32, 1)))
                         | 32'(0) ;
    return $urandom();
  endfunction

  function automatic cmd_word_t random_rule();
    cmd_word_t w;
    int unsigned pick;
    w          = blank_word(FUNC_APPEND);
    w.dir      = 2'($urandom_range(3));
    w.src_ip   = ($urandom_range(3) == 0) ? 32'd0 : $urandom();
    w.dst_ip   = ($urandom_range(3) == 0) ? 32'd0 : $urandom();
    w.src_mask = random_mask();
    w.dst_mask = random_mask();
    w.sport    = ($urandom_range(2) != 0) ? 16'd0 : 16'($urandom());
    w.dport    = ($urandom_range(2) != 0) ? 16'd0 : 16'($urandom());
    pick       = $urandom_range(9);
    w.protocol = (pick < 3) ? 8'(RPROTO_ANY) : (pick < 6) ? 8'(RPROTO_TCP) :
                 (pick < 9) ? 8'(RPROTO_UDP) : 8'($urandom());
    w.action   = 1'($urandom_range(1));
    w.src_mask = w.src_mask;
    w.number   = 5'($urandom());
    return w;
  endfunction

  // packet aimed at a stored rule so that first-match ordering gets exercised
  function automatic cmd_word_t aimed_packet();
    cmd_word_t w;
    int          k;
    logic [31:0] keep;
    int unsigned pick;
    w          = blank_word(FUNC_CLASSIFY);
    w.src_ip   = $urandom();
    w.dst_ip   = $urandom();
    w.sport    = 16'($urandom());
    w.dport    = 16'($urandom());
    w.src_mask = $urandom();
    w.dst_mask = $urandom();
    w.action   = 1'($urandom_range(1));
    w.number   = 5'($urandom());
    pick       = $urandom_range(9);
    w.protocol = (pick < 4) ? PROTO_TCP : (pick < 8) ? PROTO_UDP : 8'($urandom());
    w.dir      = 2'($urandom_range(3));
    if (shadow_count == 0) return w;
    k     = $urandom_range(shadow_count - 1);
    w.dir = shadow_dir[k];
    if (shadow_proto[k] == RPROTO_TCP) w.protocol = PROTO_TCP;
    if (shadow_proto[k] == RPROTO_UDP) w.protocol = PROTO_UDP;
    keep     = prefix_keep(shadow_src_mask[k]);
    w.src_ip = (shadow_src_addr[k] & keep) | (w.src_ip & ~keep);
    keep     = prefix_keep(shadow_dst_mask[k]);
    w.dst_ip = (shadow_dst_addr[k] & keep) | (w.dst_ip & ~keep);
    if (shadow_sport[k] != '0) w.sport = shadow_sport[k];
    if (shadow_dport[k] != '0) w.dport = shadow_dport[k];
    // now and then flip one dst_ip bit so the rule may just miss
    if ($urandom_range(7) == 0) w.dst_ip[$urandom_range(31)] ^= 1'b1;
    return w;
  endfunction

  function automatic cmd_word_t random_packet();
    cmd_word_t w;
    w          = aimed_packet();
    w.src_ip   = $urandom();
    w.dst_ip   = $urandom();
    w.dir      = 2'($urandom_range(3));
    w.protocol = 8'($urandom());
    return w;
  endfunction

  // empty table: default accept, bad deletes and the ignored function code
  task automatic test_empty_table();
    cmd_word_t w;
    w = blank_word(FUNC_CLASSIFY);
    send_word(w);
    w = blank_word(FUNC_DELETE);
    w.number = 5'd1;
    send_word(w);
    w.number = 5'd0;
    send_word(w);
    w = blank_word(FUNC_IGNORED);
    w.src_ip = '1;
    send_word(w);
  endtask

  // a few hand-made rules covering protocol codes, wildcards and direction 3
  task automatic test_basic_rules();
    cmd_word_t w;
    // inbound tcp from 10/8 to port 80: drop
    w = blank_word(FUNC_APPEND);
    w.dir = 2'd1; w.src_ip = 32'h0A00_0000; w.src_mask = 32'hFF00_0000;
    w.dport = 16'd80; w.protocol = 8'(RPROTO_TCP); w.action = 1'b0;
    send_word(w);
    // outbound anything: accept
    w = blank_word(FUNC_APPEND);
    w.dir = 2'd2; w.action = 1'b1;
    send_word(w);
    // direction 3, unknown protocol code stored as any, exact address
    w = blank_word(FUNC_APPEND);
    w.dir = 2'd3; w.dst_ip = 32'hC0A8_0101; w.protocol = 8'd255; w.sport = 16'hFFFF;
    send_word(w);
    // udp only, all-ones addresses and masks
    w = blank_word(FUNC_APPEND);
    w.dir = 2'd0; w.src_ip = '1; w.dst_ip = '1; w.src_mask = '1; w.dst_mask = '1;
    w.protocol = 8'(RPROTO_UDP); w.action = 1'b1;
    send_word(w);
    // packets
    w = blank_word(FUNC_CLASSIFY);
    w.dir = 2'd1; w.src_ip = 32'h0A12_3456; w.dport = 16'd80; w.protocol = PROTO_TCP;
    send_word(w);
    w.protocol = PROTO_UDP;
    send_word(w);
    w.dir = 2'd2; w.protocol = 8'd1;
    send_word(w);
    w = blank_word(FUNC_CLASSIFY);
    w.dir = 2'd3; w.dst_ip = 32'hC0A8_0101; w.sport = 16'hFFFF; w.protocol = PROTO_TCP;
    send_word(w);
    // ports read as zero for a non tcp/udp packet
    w.protocol = 8'd1;
    send_word(w);
    w = blank_word(FUNC_CLASSIFY);
    w.src_ip = '1; w.dst_ip = '1; w.sport = '1; w.dport = '1; w.protocol = PROTO_UDP;
    w.src_mask = '1; w.dst_mask = '1; w.action = 1'b1; w.number = '1;
    send_word(w);
    // delete the second rule, the outbound packet now falls through
    w = blank_word(FUNC_DELETE);
    w.number = 5'd2;
    send_word(w);
    w = blank_word(FUNC_CLASSIFY);
    w.dir = 2'd2;
    send_word(w);
    w = blank_word(FUNC_DELETE);
    w.number = 5'd31;
    send_word(w);
    w.number = 5'd4;
    send_word(w);
  endtask

  // fill the table, push past full, classify, then drain from random places
  task automatic test_full_table();
    cmd_word_t w;
    while (shadow_count < TableDepth) send_word(random_rule());
    send_word(random_rule());
    send_word(random_rule());
    repeat (20) send_word(aimed_packet());
    w = blank_word(FUNC_DELETE);
    w.number = 5'd17;
    send_word(w);
    w.number = 5'd16;
    send_word(w);
    w.number = 5'd1;
    send_word(w);
    while (shadow_count > 2) begin
      w.number = 5'($urandom_range(shadow_count, 1));
      send_word(w);
      send_word(aimed_packet());
    end
  endtask

  // mixed traffic: mostly packets, with rule churn and some noise
  task automatic test_random_traffic(input int unsigned count);
    cmd_word_t   w;
    int unsigned pick;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) no_gaps = ($urandom_range(2) == 0);
      pick = $urandom_range(99);
      if (pick < 40) begin
        w = aimed_packet();
      end else if (pick < 58) begin
        w = random_packet();
      end else if (pick < 78) begin
        w = random_rule();
      end else if (pick < 95) begin
        w = blank_word(FUNC_DELETE);
        w.number = ($urandom_range(4) == 0) ? 5'($urandom()) :
                   5'($urandom_range(shadow_count > 0 ? shadow_count : 1, 1));
      end else begin
        w = random_packet();
        w.func = FUNC_IGNORED;
      end
      send_word(w);
    end
    no_gaps = 1'b0;
  endtask

  // result checker and stall watchdog
  always @(posedge clk_i) begin
    verdict_word_t exp_word;
    if (rst_ni) begin
      idle_cycles <= (done_o || (start && !busy)) ? 0 : idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end
      if (done_o) begin
        if (pending_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
        end else begin
          exp_word = pending_verdicts.pop_front();
          if (verdict_o !== exp_word.verdict || hit_o !== exp_word.hit ||
              hit_position_o !== exp_word.position || status_o !== exp_word.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at %0t: exp v%0d h%0d p%0d s%0d got v%0d h%0d p%0d s%0d",
                       $realtime, exp_word.verdict, exp_word.hit, exp_word.position,
                       exp_word.status, verdict_o, hit_o, hit_position_o, status_o);
          end
        end
      end
    end
  end

  // main sequence
  initial begin
    mismatches    = 0;
    idle_cycles   = 0;
    no_gaps       = 1'b0;
    shadow_count  = 0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    func_i        = '0;
    direction_i   = '0;
    src_ip_i      = '0;
    dst_ip_i      = '0;
    sport_i       = '0;
    dport_i       = '0;
    protocol_i    = '0;
    src_mask_i    = '0;
    dst_mask_i    = '0;
    rule_action_i = 1'b0;
    rule_number_i = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_table();
    test_basic_rules();
    test_full_table();
    test_random_traffic(470);

    @(negedge clk_i);
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
design/fmprf_pkg.sv
design/fmprf_front.sv
design/fmprf_back.sv
design/first_match_packet_rule_filter_core.sv
test/first_match_packet_rule_filter_core_test.sv
